FILE: rtl/mcrb_pkg.sv
// Shared constants, codes and types of the multi-channel ring buffer.
package mcrb_pkg;

    localparam int NUM_RINGS   = 8;
    localparam int RING_DEPTH  = 256;
    localparam int MAX_BURST   = 32;

    // Handles are 4 bits wide, so at most 15 rings can be granted.
    localparam int USE_RINGS   = (NUM_RINGS < 15) ? NUM_RINGS : 15;
    localparam int RING_W      = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int STORE_DEPTH = NUM_RINGS * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BURST_W     = $clog2(MAX_BURST + 1);
    localparam int WCNT_SAT    = (RING_DEPTH < 511) ? RING_DEPTH : 511;

    localparam int FUNC_W      = 3;
    localparam int HANDLE_W    = 4;
    localparam int SIZE_W      = 9;
    localparam int LEN_W       = 6;
    localparam int DATA_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 9;

    // Index compares need room for the largest size and for index + 1.
    localparam int CMP_W       = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_OPEN  = 3'd0,
        FUNC_CLOSE = 3'd1,
        FUNC_READ  = 3'd2,
        FUNC_WRITE = 3'd3,
        FUNC_COPY  = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_PARTIAL    = 3'd2,
        ST_NO_FREE    = 3'd3,
        ST_BAD_SIZE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_PART  = 2'd0,
        MARK_EMPTY = 2'd1,
        MARK_FULL  = 2'd2
    } mark_t;

endpackage

FILE: rtl/mcrb_if.sv
// Request and response channel interfaces of the multi-channel ring buffer.
interface mcrb_req_if;
    logic                              valid;
    logic                              ready;
    logic [mcrb_pkg::FUNC_W-1:0]       func;
    logic [mcrb_pkg::HANDLE_W-1:0]     handle;
    logic [mcrb_pkg::SIZE_W-1:0]       ring_size_in;
    logic [mcrb_pkg::LEN_W-1:0]        length;
    logic [mcrb_pkg::DATA_W-1:0]       data_byte;
    logic                              end_of_write;

    modport source
    (
        output valid, func, handle, ring_size_in, length, data_byte, end_of_write,
        input  ready
    );

    modport sink
    (
        input  valid, func, handle, ring_size_in, length, data_byte, end_of_write,
        output ready
    );
endinterface

interface mcrb_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mcrb_pkg::HANDLE_W-1:0]     handle_out;
    logic [mcrb_pkg::DATA_W-1:0]       data_out;
    logic                              data_valid;
    logic                              last;
    logic [mcrb_pkg::STATUS_W-1:0]     status;
    logic [mcrb_pkg::COUNT_W-1:0]      count;

    modport source
    (
        output valid, handle_out, data_out, data_valid, last, status, count,
        input  ready
    );

    modport sink
    (
        input  valid, handle_out, data_out, data_valid, last, status, count,
        output ready
    );
endinterface

FILE: rtl/multi_channel_ring_buffer_core.sv
// Pool of byte rings sharing one byte store: open, close, write, read and copy.
//
// Open, close and write words are answered directly: the response word is
// loaded at the accepting edge, and the next request can be taken as soon as
// that word is being drained. A read or copy of n bytes gives n response words
// at one per cycle while the response side takes them. The first word comes
// later than a single-word response, because the byte store read is registered;
// its single read port sets the pace. A burst holds the request side until
// its last word is loaded. A request is taken only while no burst is in
// flight and the response register is empty or being drained, so a stalled
// response side stalls the request side. Ring descriptors live in registers;
// bytes live in a store of NUM_RINGS * RING_DEPTH entries, ring r owning the
// region starting at r * RING_DEPTH. No clearing pass follows reset.
module multi_channel_ring_buffer_core
(
    input  logic        clk,
    input  logic        rst_n,
    mcrb_req_if.sink    req,
    mcrb_rsp_if.source  rsp
);

    typedef enum logic {
        S_IDLE,
        S_BURST
    } state_t;

    // control state
    state_t                              state_reg, state_next;
    logic [mcrb_pkg::NUM_RINGS-1:0]      ring_open_reg, ring_open_next;
    logic [mcrb_pkg::COUNT_W-1:0]        wr_cnt_reg, wr_cnt_next;
    logic                                wr_short_reg, wr_short_next;
    logic                                rd_avail_reg, rd_avail_next;
    logic [mcrb_pkg::BURST_W-1:0]        b_issue_left_reg, b_issue_left_next;
    logic [mcrb_pkg::BURST_W-1:0]        b_out_left_reg, b_out_left_next;
    logic [mcrb_pkg::BURST_W-1:0]        b_count_reg, b_count_next;
    logic [mcrb_pkg::RING_W-1:0]         b_ring_reg, b_ring_next;
    logic [mcrb_pkg::IDX_W-1:0]          b_rd_idx_reg, b_rd_idx_next;
    logic                                b_short_reg, b_short_next;
    logic                                b_consume_reg, b_consume_next;

    // response register
    logic                                out_valid_reg, out_valid_next;
    logic [mcrb_pkg::HANDLE_W-1:0]       out_handle_reg, out_handle_next;
    logic [mcrb_pkg::DATA_W-1:0]         out_data_reg, out_data_next;
    logic                                out_dvalid_reg, out_dvalid_next;
    logic                                out_last_reg, out_last_next;
    logic [mcrb_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [mcrb_pkg::COUNT_W-1:0]        out_count_reg, out_count_next;

    // ring descriptors, meaningful only while the ring is open
    logic [mcrb_pkg::SIZE_W-1:0]         size_reg [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::SIZE_W-1:0]         size_next [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]          head_reg [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]          head_next [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]          tail_reg [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]          tail_next [mcrb_pkg::NUM_RINGS];
    mcrb_pkg::mark_t                     mark_reg [mcrb_pkg::NUM_RINGS];
    mcrb_pkg::mark_t                     mark_next [mcrb_pkg::NUM_RINGS];

    // byte store
    logic [mcrb_pkg::DATA_W-1:0]         store_mem [mcrb_pkg::STORE_DEPTH];
    logic [mcrb_pkg::DATA_W-1:0]         rd_data_reg;
    logic                                mem_we;
    logic                                mem_re;
    logic [mcrb_pkg::ADDR_W-1:0]         mem_waddr;
    logic [mcrb_pkg::ADDR_W-1:0]         mem_raddr;

    // request decode
    logic                                out_free;
    logic                                accept;
    logic [mcrb_pkg::HANDLE_W-1:0]       handle_m1;
    logic [mcrb_pkg::RING_W-1:0]         req_ring;
    logic                                hdl_ok;
    logic [mcrb_pkg::SIZE_W-1:0]         cur_sz;
    logic [mcrb_pkg::IDX_W-1:0]          cur_hd;
    logic [mcrb_pkg::IDX_W-1:0]          cur_tl;
    mcrb_pkg::mark_t                     cur_mk;
    logic [mcrb_pkg::CMP_W-1:0]          avail;
    logic [mcrb_pkg::BURST_W-1:0]        req_len;
    logic [mcrb_pkg::BURST_W-1:0]        n_len;
    logic                                free_found;
    logic [mcrb_pkg::RING_W-1:0]         free_idx;

    function automatic logic [mcrb_pkg::IDX_W-1:0] advance
    (
        input logic [mcrb_pkg::IDX_W-1:0]  idx,
        input logic [mcrb_pkg::SIZE_W-1:0] sz
    );
        logic [mcrb_pkg::CMP_W-1:0] nx;
        nx = mcrb_pkg::CMP_W'(idx) + mcrb_pkg::CMP_W'(1);
        return (nx >= mcrb_pkg::CMP_W'(sz)) ? '0 : nx[mcrb_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [mcrb_pkg::ADDR_W-1:0] addr_of
    (
        input logic [mcrb_pkg::RING_W-1:0] ring,
        input logic [mcrb_pkg::IDX_W-1:0]  idx
    );
        return mcrb_pkg::ADDR_W'(ring) * mcrb_pkg::ADDR_W'(mcrb_pkg::RING_DEPTH)
               + mcrb_pkg::ADDR_W'(idx);
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.data_out   = out_data_reg;
    assign rsp.data_valid = out_dvalid_reg;
    assign rsp.last       = out_last_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.count      = out_count_reg;

    assign handle_m1 = req.handle - mcrb_pkg::HANDLE_W'(1);
    assign req_ring  = handle_m1[mcrb_pkg::RING_W-1:0];
    assign hdl_ok    = (req.handle != '0) && (int'(req.handle) <= mcrb_pkg::USE_RINGS)
                       && ring_open_reg[req_ring];
    assign cur_sz    = size_reg[req_ring];
    assign cur_hd    = head_reg[req_ring];
    assign cur_tl    = tail_reg[req_ring];
    assign cur_mk    = mark_reg[req_ring];

    always_comb
    begin
        if (cur_mk == mcrb_pkg::MARK_FULL)
        begin
            avail = mcrb_pkg::CMP_W'(cur_sz);
        end
        else if (cur_mk == mcrb_pkg::MARK_EMPTY)
        begin
            avail = '0;
        end
        else if (cur_tl >= cur_hd)
        begin
            avail = mcrb_pkg::CMP_W'(cur_tl) - mcrb_pkg::CMP_W'(cur_hd);
        end
        else
        begin
            avail = mcrb_pkg::CMP_W'(cur_sz) - mcrb_pkg::CMP_W'(cur_hd)
                    + mcrb_pkg::CMP_W'(cur_tl);
        end
    end

    // clip the burst, then cut it to what the ring holds
    always_comb
    begin
        if (int'(req.length) > mcrb_pkg::MAX_BURST)
        begin
            req_len = mcrb_pkg::BURST_W'(mcrb_pkg::MAX_BURST);
        end
        else
        begin
            req_len = mcrb_pkg::BURST_W'(req.length);
        end
        if (mcrb_pkg::CMP_W'(req_len) < avail)
        begin
            n_len = req_len;
        end
        else
        begin
            n_len = avail[mcrb_pkg::BURST_W-1:0];
        end
    end

    // lowest closed ring
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mcrb_pkg::USE_RINGS - 1; i >= 0; i--)
        begin
            if (!ring_open_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = mcrb_pkg::RING_W'(i);
            end
        end
    end

    always_comb
    begin
        logic                          e_fire;
        logic [mcrb_pkg::HANDLE_W-1:0] e_handle;
        logic [mcrb_pkg::DATA_W-1:0]   e_data;
        logic                          e_dvalid;
        logic                          e_last;
        logic [mcrb_pkg::STATUS_W-1:0] e_status;
        logic [mcrb_pkg::COUNT_W-1:0]  e_count;
        logic [mcrb_pkg::IDX_W-1:0]    new_tl;
        logic [mcrb_pkg::COUNT_W-1:0]  cnt_new;
        logic                          short_new;
        logic                          take;
        logic                          issue;

        state_next        = state_reg;
        ring_open_next    = ring_open_reg;
        wr_cnt_next       = wr_cnt_reg;
        wr_short_next     = wr_short_reg;
        rd_avail_next     = rd_avail_reg;
        b_issue_left_next = b_issue_left_reg;
        b_out_left_next   = b_out_left_reg;
        b_count_next      = b_count_reg;
        b_ring_next       = b_ring_reg;
        b_rd_idx_next     = b_rd_idx_reg;
        b_short_next      = b_short_reg;
        b_consume_next    = b_consume_reg;
        size_next         = size_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        mark_next         = mark_reg;

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_handle_next   = out_handle_reg;
        out_data_next     = out_data_reg;
        out_dvalid_next   = out_dvalid_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = addr_of(req_ring, cur_tl);
        mem_raddr = addr_of(b_ring_reg, b_rd_idx_reg);

        e_fire    = 1'b0;
        e_handle  = '0;
        e_data    = '0;
        e_dvalid  = 1'b0;
        e_last    = 1'b1;
        e_status  = mcrb_pkg::ST_OK;
        e_count   = '0;
        new_tl    = advance(cur_tl, cur_sz);
        cnt_new   = wr_cnt_reg;
        short_new = wr_short_reg;
        take      = 1'b0;
        issue     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        mcrb_pkg::FUNC_OPEN:
                        begin
                            e_fire = 1'b1;
                            if (req.ring_size_in == '0
                                || int'(req.ring_size_in) > mcrb_pkg::RING_DEPTH)
                            begin
                                e_status = mcrb_pkg::ST_BAD_SIZE;
                            end
                            else if (!free_found)
                            begin
                                e_status = mcrb_pkg::ST_NO_FREE;
                            end
                            else
                            begin
                                ring_open_next[free_idx] = 1'b1;
                                size_next[free_idx]      = req.ring_size_in;
                                head_next[free_idx]      = '0;
                                tail_next[free_idx]      = '0;
                                mark_next[free_idx]      = mcrb_pkg::MARK_EMPTY;
                                e_handle = mcrb_pkg::HANDLE_W'(free_idx)
                                           + mcrb_pkg::HANDLE_W'(1);
                            end
                        end
                        mcrb_pkg::FUNC_CLOSE:
                        begin
                            e_fire = 1'b1;
                            if (hdl_ok)
                            begin
                                ring_open_next[req_ring] = 1'b0;
                            end
                            else
                            begin
                                e_status = mcrb_pkg::ST_BAD_HANDLE;
                            end
                        end
                        mcrb_pkg::FUNC_READ,
                        mcrb_pkg::FUNC_COPY:
                        begin
                            if (!hdl_ok)
                            begin
                                e_fire   = 1'b1;
                                e_status = mcrb_pkg::ST_BAD_HANDLE;
                            end
                            else if (cur_mk == mcrb_pkg::MARK_EMPTY)
                            begin
                                e_fire   = 1'b1;
                                e_status = mcrb_pkg::ST_PARTIAL;
                            end
                            else if (req_len == '0)
                            begin
                                e_fire = 1'b1;
                            end
                            else
                            begin
                                // fetch the first byte now, the rest in the burst
                                mem_re            = 1'b1;
                                mem_raddr         = addr_of(req_ring, cur_hd);
                                rd_avail_next     = 1'b1;
                                b_ring_next       = req_ring;
                                b_rd_idx_next     = advance(cur_hd, cur_sz);
                                b_issue_left_next = n_len - mcrb_pkg::BURST_W'(1);
                                b_out_left_next   = n_len;
                                b_count_next      = n_len;
                                b_short_next      = n_len < req_len;
                                b_consume_next    = req.func == mcrb_pkg::FUNC_READ;
                                state_next        = S_BURST;
                            end
                        end
                        mcrb_pkg::FUNC_WRITE:
                        begin
                            e_fire = 1'b1;
                            e_last = req.end_of_write;
                            if (!hdl_ok)
                            begin
                                e_status = mcrb_pkg::ST_BAD_HANDLE;
                                e_count  = wr_cnt_reg;
                            end
                            else
                            begin
                                if (cur_mk == mcrb_pkg::MARK_FULL)
                                begin
                                    short_new = 1'b1;
                                end
                                else
                                begin
                                    mem_we              = 1'b1;
                                    tail_next[req_ring] = new_tl;
                                    mark_next[req_ring] = (new_tl == cur_hd)
                                                          ? mcrb_pkg::MARK_FULL
                                                          : mcrb_pkg::MARK_PART;
                                    if (wr_cnt_reg
                                        < mcrb_pkg::COUNT_W'(mcrb_pkg::WCNT_SAT))
                                    begin
                                        cnt_new = wr_cnt_reg + mcrb_pkg::COUNT_W'(1);
                                    end
                                end
                                e_status = short_new ? mcrb_pkg::ST_PARTIAL
                                                     : mcrb_pkg::ST_OK;
                                e_count  = cnt_new;
                            end
                            // clear the run counters at the end of a run
                            if (req.end_of_write)
                            begin
                                wr_cnt_next   = '0;
                                wr_short_next = 1'b0;
                            end
                            else
                            begin
                                wr_cnt_next   = cnt_new;
                                wr_short_next = short_new;
                            end
                        end
                        default:
                        begin
                            e_fire = 1'b0;
                        end
                    endcase
                end
            end
            S_BURST:
            begin
                take  = rd_avail_reg && out_free;
                issue = (b_issue_left_reg != '0) && (!rd_avail_reg || out_free);
                if (issue)
                begin
                    mem_re            = 1'b1;
                    b_rd_idx_next     = advance(b_rd_idx_reg, size_reg[b_ring_reg]);
                    b_issue_left_next = b_issue_left_reg - mcrb_pkg::BURST_W'(1);
                end
                rd_avail_next = issue || (rd_avail_reg && !take);
                if (take)
                begin
                    e_fire          = 1'b1;
                    e_data          = rd_data_reg;
                    e_dvalid        = 1'b1;
                    e_last          = b_out_left_reg == mcrb_pkg::BURST_W'(1);
                    b_out_left_next = b_out_left_reg - mcrb_pkg::BURST_W'(1);
                    if (e_last)
                    begin
                        e_status   = b_short_reg ? mcrb_pkg::ST_PARTIAL : mcrb_pkg::ST_OK;
                        e_count    = mcrb_pkg::COUNT_W'(b_count_reg);
                        state_next = S_IDLE;
                        // all reads issued: the read index is the new head
                        if (b_consume_reg)
                        begin
                            head_next[b_ring_reg] = b_rd_idx_reg;
                            mark_next[b_ring_reg] = (b_rd_idx_reg == tail_reg[b_ring_reg])
                                                    ? mcrb_pkg::MARK_EMPTY
                                                    : mcrb_pkg::MARK_PART;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (e_fire)
        begin
            out_valid_next  = 1'b1;
            out_handle_next = e_handle;
            out_data_next   = e_data;
            out_dvalid_next = e_dvalid;
            out_last_next   = e_last;
            out_status_next = e_status;
            out_count_next  = e_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ring_open_reg    <= '0;
            wr_cnt_reg       <= '0;
            wr_short_reg     <= 1'b0;
            rd_avail_reg     <= 1'b0;
            b_issue_left_reg <= '0;
            b_out_left_reg   <= '0;
            b_count_reg      <= '0;
            b_ring_reg       <= '0;
            b_rd_idx_reg     <= '0;
            b_short_reg      <= 1'b0;
            b_consume_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_handle_reg   <= '0;
            out_data_reg     <= '0;
            out_dvalid_reg   <= 1'b0;
            out_last_reg     <= 1'b0;
            out_status_reg   <= '0;
            out_count_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            ring_open_reg    <= ring_open_next;
            wr_cnt_reg       <= wr_cnt_next;
            wr_short_reg     <= wr_short_next;
            rd_avail_reg     <= rd_avail_next;
            b_issue_left_reg <= b_issue_left_next;
            b_out_left_reg   <= b_out_left_next;
            b_count_reg      <= b_count_next;
            b_ring_reg       <= b_ring_next;
            b_rd_idx_reg     <= b_rd_idx_next;
            b_short_reg      <= b_short_next;
            b_consume_reg    <= b_consume_next;
            out_valid_reg    <= out_valid_next;
            out_handle_reg   <= out_handle_next;
            out_data_reg     <= out_data_next;
            out_dvalid_reg   <= out_dvalid_next;
            out_last_reg     <= out_last_next;
            out_status_reg   <= out_status_next;
            out_count_reg    <= out_count_next;
        end
    end

    // descriptors are rewritten on open, so they need no reset
    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        mark_reg <= mark_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= req.data_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    a_fetch_only_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        rd_avail_reg |-> state_reg == S_BURST)
        else $error("fetched byte pending outside a burst");

    a_burst_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BURST |->
            ({1'b0, b_out_left_reg}
             == {1'b0, b_issue_left_reg} + {{mcrb_pkg::BURST_W{1'b0}}, rd_avail_reg}))
        else $error("burst byte counters out of step");

    a_burst_ring_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BURST |-> ring_open_reg[b_ring_reg])
        else $error("burst on a closed ring");

    a_burst_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BURST |-> mark_reg[b_ring_reg] != mcrb_pkg::MARK_EMPTY)
        else $error("burst on an empty ring");

endmodule

FILE: tb/multi_channel_ring_buffer_core_tb.sv
// Self-checking testbench for the multi-channel ring buffer core.
module multi_channel_ring_buffer_core_tb;

    localparam logic [mcrb_pkg::FUNC_W-1:0] FUNC_RESERVED = 3'd7;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 50;

    typedef struct packed {
        logic [mcrb_pkg::HANDLE_W-1:0] handle_out;
        logic [mcrb_pkg::DATA_W-1:0]   data_out;
        logic                          data_valid;
        logic                          last;
        logic [mcrb_pkg::STATUS_W-1:0] status;
        logic [mcrb_pkg::COUNT_W-1:0]  count;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    mcrb_req_if req_bus();
    mcrb_rsp_if rsp_bus();

    multi_channel_ring_buffer_core u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Image of the ring pool, kept in step with accepted request words
    logic                         ring_live  [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::SIZE_W-1:0]  ring_len   [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]   head_at    [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::IDX_W-1:0]   tail_at    [mcrb_pkg::NUM_RINGS];
    mcrb_pkg::mark_t              fill       [mcrb_pkg::NUM_RINGS];
    logic [mcrb_pkg::DATA_W-1:0]  byte_store [mcrb_pkg::STORE_DEPTH];
    logic [mcrb_pkg::COUNT_W-1:0] run_stored;
    logic                         run_dropped;

    rsp_word_t due_words[$];
    int   mismatches   = 0;
    int   sent_items   = 0;
    int   src_gap_pct  = 0;
    int   sink_gap_pct = 0;
    logic rsp_hold     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_pool();
        for (int i = 0; i < mcrb_pkg::NUM_RINGS; i++)
        begin
            ring_live[i] = 1'b0;
            ring_len[i]  = '0;
            head_at[i]   = '0;
            tail_at[i]   = '0;
            fill[i]      = mcrb_pkg::MARK_EMPTY;
        end
        for (int i = 0; i < mcrb_pkg::STORE_DEPTH; i++)
            byte_store[i] = '0;
        run_stored  = '0;
        run_dropped = 1'b0;
    endfunction

    function automatic int ring_index(input logic [mcrb_pkg::HANDLE_W-1:0] h);
        if (h < 1 || h > mcrb_pkg::NUM_RINGS || h > 15)
            return -1;
        if (!ring_live[h - 1])
            return -1;
        return int'(h) - 1;
    endfunction

    function automatic int fill_level(input int r);
        if (fill[r] == mcrb_pkg::MARK_FULL)
            return int'(ring_len[r]);
        if (fill[r] == mcrb_pkg::MARK_EMPTY)
            return 0;
        if (tail_at[r] >= head_at[r])
            return int'(tail_at[r]) - int'(head_at[r]);
        return int'(ring_len[r]) - int'(head_at[r]) + int'(tail_at[r]);
    endfunction

    function automatic logic [mcrb_pkg::IDX_W-1:0] next_index
    (
        input int                         r,
        input logic [mcrb_pkg::IDX_W-1:0] idx
    );
        logic [mcrb_pkg::CMP_W-1:0] n;
        n = mcrb_pkg::CMP_W'(idx) + mcrb_pkg::CMP_W'(1);
        return (n >= mcrb_pkg::CMP_W'(ring_len[r])) ? '0 : n[mcrb_pkg::IDX_W-1:0];
    endfunction

    function automatic void push_word
    (
        input logic [mcrb_pkg::HANDLE_W-1:0] h,
        input logic [mcrb_pkg::DATA_W-1:0]   d,
        input logic                          v,
        input logic                          fin,
        input mcrb_pkg::status_t             st,
        input logic [mcrb_pkg::COUNT_W-1:0]  cnt
    );
        rsp_word_t w;
        w.handle_out = h;
        w.data_out   = d;
        w.data_valid = v;
        w.last       = fin;
        w.status     = st;
        w.count      = cnt;
        due_words.push_back(w);
    endfunction

    // Advance the pool image by one request word and queue the words it owes
    function automatic void ring_pool_step
    (
        input logic [mcrb_pkg::FUNC_W-1:0]   f,
        input logic [mcrb_pkg::HANDLE_W-1:0] h,
        input logic [mcrb_pkg::SIZE_W-1:0]   sz,
        input logic [mcrb_pkg::LEN_W-1:0]    len,
        input logic [mcrb_pkg::DATA_W-1:0]   d,
        input logic                          eow
    );
        int r;
        int asked;
        int n;
        logic [mcrb_pkg::IDX_W-1:0] pos;
        logic [mcrb_pkg::HANDLE_W-1:0] granted;
        mcrb_pkg::status_t st;
        logic found;
        r = ring_index(h);
        case (f)
            mcrb_pkg::FUNC_OPEN:
            begin
                if (sz == 0 || sz > mcrb_pkg::RING_DEPTH)
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_BAD_SIZE, '0);
                else
                begin
                    found = 1'b0;
                    for (int i = 0; i < mcrb_pkg::USE_RINGS && !found; i++)
                    begin
                        if (!ring_live[i])
                        begin
                            ring_live[i] = 1'b1;
                            ring_len[i]  = sz;
                            head_at[i]   = '0;
                            tail_at[i]   = '0;
                            fill[i]      = mcrb_pkg::MARK_EMPTY;
                            granted      = mcrb_pkg::HANDLE_W'(i + 1);
                            found        = 1'b1;
                            push_word(granted, '0, 1'b0, 1'b1, mcrb_pkg::ST_OK, '0);
                        end
                    end
                    if (!found)
                        push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_NO_FREE, '0);
                end
            end
            mcrb_pkg::FUNC_CLOSE:
            begin
                if (r < 0)
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_BAD_HANDLE, '0);
                else
                begin
                    ring_live[r] = 1'b0;
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_OK, '0);
                end
            end
            mcrb_pkg::FUNC_READ, mcrb_pkg::FUNC_COPY:
            begin
                asked = (len > mcrb_pkg::MAX_BURST) ? mcrb_pkg::MAX_BURST : int'(len);
                if (r < 0)
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_BAD_HANDLE, '0);
                else if (fill[r] == mcrb_pkg::MARK_EMPTY)
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_PARTIAL, '0);
                else if (asked == 0)
                    push_word('0, '0, 1'b0, 1'b1, mcrb_pkg::ST_OK, '0);
                else
                begin
                    n   = (asked < fill_level(r)) ? asked : fill_level(r);
                    pos = head_at[r];
                    for (int i = 0; i < n; i++)
                    begin
                        if (i + 1 == n)
                            push_word('0, byte_store[r * mcrb_pkg::RING_DEPTH + int'(pos)],
                                      1'b1, 1'b1,
                                      (n < asked) ? mcrb_pkg::ST_PARTIAL : mcrb_pkg::ST_OK,
                                      mcrb_pkg::COUNT_W'(n));
                        else
                            push_word('0, byte_store[r * mcrb_pkg::RING_DEPTH + int'(pos)],
                                      1'b1, 1'b0, mcrb_pkg::ST_OK, '0);
                        pos = next_index(r, pos);
                    end
                    // consume only on read; copy leaves the ring as it was
                    if (f == mcrb_pkg::FUNC_READ)
                    begin
                        head_at[r] = pos;
                        fill[r]    = (pos == tail_at[r]) ? mcrb_pkg::MARK_EMPTY
                                                         : mcrb_pkg::MARK_PART;
                    end
                end
            end
            mcrb_pkg::FUNC_WRITE:
            begin
                if (r < 0)
                    st = mcrb_pkg::ST_BAD_HANDLE;
                else
                begin
                    if (fill[r] == mcrb_pkg::MARK_FULL)
                        run_dropped = 1'b1;
                    else
                    begin
                        byte_store[r * mcrb_pkg::RING_DEPTH + int'(tail_at[r])] = d;
                        tail_at[r] = next_index(r, tail_at[r]);
                        fill[r]    = (tail_at[r] == head_at[r]) ? mcrb_pkg::MARK_FULL
                                                                : mcrb_pkg::MARK_PART;
                        if (run_stored < mcrb_pkg::WCNT_SAT)
                            run_stored++;
                    end
                    st = run_dropped ? mcrb_pkg::ST_PARTIAL : mcrb_pkg::ST_OK;
                end
                push_word('0, '0, 1'b0, eow, st, run_stored);
                if (eow)
                begin
                    run_stored  = '0;
                    run_dropped = 1'b0;
                end
            end
            default:
            begin
                // reserved codes are dropped by the block
            end
        endcase
    endfunction

    function automatic logic [mcrb_pkg::HANDLE_W-1:0] live_handle();
        int picks[$];
        for (int i = 0; i < mcrb_pkg::USE_RINGS; i++)
            if (ring_live[i])
                picks.push_back(i + 1);
        if (picks.size() == 0)
            return '0;
        return mcrb_pkg::HANDLE_W'(picks[$urandom_range(picks.size() - 1)]);
    endfunction

    function automatic logic [mcrb_pkg::LEN_W-1:0] pick_length
    (
        input logic [mcrb_pkg::HANDLE_W-1:0] h
    );
        int r;
        int lvl;
        r = ring_index(h);
        if (r < 0 || $urandom_range(7) == 0)
            return mcrb_pkg::LEN_W'($urandom_range(63));
        lvl = fill_level(r) + 2;
        if (lvl > 63)
            lvl = 63;
        return mcrb_pkg::LEN_W'($urandom_range(lvl));
    endfunction

    // Response side: random stalls, plus a forced hold-off when asked
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= sink_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_word_t got;
        rsp_word_t want;
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            got.handle_out = rsp_bus.handle_out;
            got.data_out   = rsp_bus.data_out;
            got.data_valid = rsp_bus.data_valid;
            got.last       = rsp_bus.last;
            got.status     = rsp_bus.status;
            got.count      = rsp_bus.count;
            if (due_words.size() == 0)
            begin
                mismatches++;
                $display({"%0t: response word with none due: expected none, ",
                          "got h=%0d d=%h v=%b last=%b st=%0d cnt=%0d"},
                         $time, got.handle_out, got.data_out, got.data_valid, got.last,
                         got.status, got.count);
            end
            else
            begin
                want = due_words.pop_front();
                if (got.handle_out !== want.handle_out || got.data_out !== want.data_out ||
                    got.data_valid !== want.data_valid || got.last !== want.last ||
                    got.status !== want.status || got.count !== want.count)
                begin
                    mismatches++;
                    $display({"%0t: response word mismatch: ",
                              "expected h=%0d d=%h v=%b last=%b st=%0d cnt=%0d, ",
                              "got h=%0d d=%h v=%b last=%b st=%0d cnt=%0d"},
                             $time, want.handle_out, want.data_out, want.data_valid,
                             want.last, want.status, want.count, got.handle_out,
                             got.data_out, got.data_valid, got.last, got.status,
                             got.count);
                end
            end
        end
    end

    // Offer one request word, hold it until taken, then update the pool image
    task automatic send_word
    (
        input logic [mcrb_pkg::FUNC_W-1:0]   f,
        input logic [mcrb_pkg::HANDLE_W-1:0] h,
        input logic [mcrb_pkg::SIZE_W-1:0]   sz,
        input logic [mcrb_pkg::LEN_W-1:0]    len,
        input logic [mcrb_pkg::DATA_W-1:0]   d,
        input logic                          eow
    );
        if ($urandom_range(99) < src_gap_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_gap_pct)
                @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.func         <= f;
        req_bus.handle       <= h;
        req_bus.ring_size_in <= sz;
        req_bus.length       <= len;
        req_bus.data_byte    <= d;
        req_bus.end_of_write <= eow;
        do
            @(posedge clk);
        while (!(req_bus.valid && req_bus.ready));
        ring_pool_step(f, h, sz, len, d, eow);
        if (f <= mcrb_pkg::FUNC_COPY)
            sent_items++;
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_words.size() != 0);
    endtask

    task automatic hold_rsp_side(input int cycles);
        rsp_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rsp_hold <= 1'b0;
    endtask

    task automatic test_corner_cases();
        src_gap_pct  = 17;
        sink_gap_pct = 17;
        send_word(mcrb_pkg::FUNC_READ, 4'd1, '0, 6'd4, '0, 1'b0);    // nothing open yet
        send_word(mcrb_pkg::FUNC_CLOSE, 4'd0, '0, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_CLOSE, 4'd15, '0, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_CLOSE, 4'd9, '0, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd0, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd257, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd511, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd256, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd1, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd2, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_READ, 4'd1, '0, 6'd8, '0, 1'b0);    // empty ring
        send_word(mcrb_pkg::FUNC_COPY, 4'd1, '0, 6'd8, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_WRITE, 4'd2, '0, '0, 8'hff, 1'b0);
        send_word(mcrb_pkg::FUNC_WRITE, 4'd2, '0, '0, 8'h00, 1'b1);  // ring full, byte dropped
        send_word(mcrb_pkg::FUNC_READ, 4'd2, '0, 6'd0, '0, 1'b0);    // zero length, full ring
        send_word(mcrb_pkg::FUNC_COPY, 4'd2, '0, 6'd63, '0, 1'b0);   // cut to burst limit, short
        send_word(mcrb_pkg::FUNC_READ, 4'd2, '0, 6'd1, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_WRITE, 4'd0, '0, '0, 8'h5a, 1'b1);
        send_word(FUNC_RESERVED, 4'd1, '0, 6'd3, '0, 1'b0);
        for (int i = 0; i < mcrb_pkg::NUM_RINGS - 3; i++)
            send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd16, '0, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_OPEN, '0, 9'd16, '0, '0, 1'b0);     // pool exhausted
        wait_drained();
    endtask

    // Stall the response side while a long write run piles up, then drain it
    task automatic test_backpressure_saturation();
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        fork
            hold_rsp_side(HOLD_CYCLES);
            begin
                for (int i = 0; i < mcrb_pkg::RING_DEPTH + 10; i++)
                    send_word(mcrb_pkg::FUNC_WRITE, 4'd1, '0, '0,
                              mcrb_pkg::DATA_W'($urandom), 1'b0);
                for (int i = 0; i < 10; i++)
                    send_word(mcrb_pkg::FUNC_WRITE, 4'd3, '0, '0,
                              mcrb_pkg::DATA_W'($urandom), 1'b0);
                send_word(mcrb_pkg::FUNC_WRITE, 4'd3, '0, '0,
                          mcrb_pkg::DATA_W'($urandom), 1'b1);
            end
        join
        send_word(mcrb_pkg::FUNC_READ, 4'd1, '0, 6'd63, '0, 1'b0);
        for (int i = 0; i < mcrb_pkg::RING_DEPTH / mcrb_pkg::MAX_BURST - 1; i++)
            send_word(mcrb_pkg::FUNC_READ, 4'd1, '0, 6'd32, '0, 1'b0);
        send_word(mcrb_pkg::FUNC_READ, 4'd3, '0, 6'd63, '0, 1'b0);
        wait_drained();
    endtask

    task automatic random_op();
        int pick;
        int run;
        logic [mcrb_pkg::HANDLE_W-1:0] h;
        logic [mcrb_pkg::SIZE_W-1:0] sz;
        pick = $urandom_range(99);
        h = live_handle();
        if (h == 0 && pick < 92)
            pick = 0;
        if (pick < 8)
        begin
            sz = ($urandom_range(9) == 0) ? mcrb_pkg::SIZE_W'($urandom_range(511))
                                          : mcrb_pkg::SIZE_W'($urandom_range(24, 1));
            send_word(mcrb_pkg::FUNC_OPEN, mcrb_pkg::HANDLE_W'($urandom), sz,
                      mcrb_pkg::LEN_W'($urandom), mcrb_pkg::DATA_W'($urandom),
                      1'($urandom));
        end
        else if (pick < 14)
        begin
            if ($urandom_range(4) == 0)
                h = mcrb_pkg::HANDLE_W'($urandom_range(15));
            send_word(mcrb_pkg::FUNC_CLOSE, h, mcrb_pkg::SIZE_W'($urandom),
                      mcrb_pkg::LEN_W'($urandom), mcrb_pkg::DATA_W'($urandom),
                      1'($urandom));
        end
        else if (pick < 50)
        begin
            run = $urandom_range(10, 1);
            if ($urandom_range(9) == 0)
                h = mcrb_pkg::HANDLE_W'($urandom_range(15));
            for (int i = 0; i < run; i++)
            begin
                if ($urandom_range(19) == 0)
                    h = mcrb_pkg::HANDLE_W'($urandom_range(15));
                send_word(mcrb_pkg::FUNC_WRITE, h, mcrb_pkg::SIZE_W'($urandom),
                          mcrb_pkg::LEN_W'($urandom), mcrb_pkg::DATA_W'($urandom),
                          (i == run - 1) && ($urandom_range(9) != 0));
            end
        end
        else if (pick < 72)
        begin
            if ($urandom_range(9) == 0)
                h = mcrb_pkg::HANDLE_W'($urandom_range(15));
            send_word(mcrb_pkg::FUNC_READ, h, mcrb_pkg::SIZE_W'($urandom), pick_length(h),
                      mcrb_pkg::DATA_W'($urandom), 1'($urandom));
        end
        else if (pick < 92)
        begin
            if ($urandom_range(9) == 0)
                h = mcrb_pkg::HANDLE_W'($urandom_range(15));
            send_word(mcrb_pkg::FUNC_COPY, h, mcrb_pkg::SIZE_W'($urandom), pick_length(h),
                      mcrb_pkg::DATA_W'($urandom), 1'($urandom));
        end
        else
            send_word(mcrb_pkg::FUNC_W'($urandom_range(7)), mcrb_pkg::HANDLE_W'($urandom),
                      mcrb_pkg::SIZE_W'($urandom), mcrb_pkg::LEN_W'($urandom),
                      mcrb_pkg::DATA_W'($urandom), 1'($urandom));
    endtask

    task automatic test_random_mix(input int src_pct, input int sink_pct, input int n);
        int stop_at;
        src_gap_pct  = src_pct;
        sink_gap_pct = sink_pct;
        stop_at      = sent_items + n;
        while (sent_items < stop_at)
            random_op();
        wait_drained();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.func         = mcrb_pkg::FUNC_OPEN;
        req_bus.handle       = '0;
        req_bus.ring_size_in = '0;
        req_bus.length       = '0;
        req_bus.data_byte    = '0;
        req_bus.end_of_write = 1'b0;
        clear_pool();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        test_backpressure_saturation();
        test_random_mix(17, 83, RANDOM_ITEMS);
        test_random_mix(83, 17, RANDOM_ITEMS);
        test_random_mix(0, 0, RANDOM_ITEMS);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mcrb_pkg.sv
rtl/mcrb_if.sv
rtl/multi_channel_ring_buffer_core.sv
tb/multi_channel_ring_buffer_core_tb.sv
